### rtl/ellipse_span_with_soft_edge_assert.svh
// Assertion macros for the ellipse span block.
// Used by the top level; depends on signals named clk and arst_n in scope.
`ifndef ELLIPSE_SPAN_WITH_SOFT_EDGE_ASSERT_SVH
`define ELLIPSE_SPAN_WITH_SOFT_EDGE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ELLSPAN_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ellipse span check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ELLSPAN_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ellipse span check failed");

`endif

### rtl/ellspan_pkg.sv
// Shared types, constants and functions of the ellipse span block.
// No dependencies; used by every module of the block.
package ellspan_pkg;

	localparam int ALPHA_BITS = 8;
	localparam int HALF_WIDTH_BITS = 11;
	localparam int OUT_DATA_W = ((HALF_WIDTH_BITS + 2 * ALPHA_BITS + 7) / 8) * 8;

	// Division by three of a value below 512 as a multiply by 683 / 2048.
	localparam int FADE_MUL = 683;
	localparam int FADE_SHIFT = 11;

	typedef struct packed {
		logic                  ok;
		logic [ALPHA_BITS-1:0] outer;
		logic [ALPHA_BITS-1:0] inner;
	} side_t;

	function automatic logic [ALPHA_BITS-1:0] div3(input logic [ALPHA_BITS:0] x);
		logic [19:0] prod;
		prod = 20'(x) * 20'(FADE_MUL);
		return ALPHA_BITS'(prod >> FADE_SHIFT);
	endfunction

endpackage

### rtl/ellipse_span_with_soft_edge.sv
// Top level of the filled-ellipse scanline span block with soft-edge alphas.
// Depends on ellspan_pkg, ellspan_div, ellspan_sqrt and the assertion header.
//
// Channel   Dir  Fields (tdata / tuser, lowest bits first)
// s_*       in   tdata: radius_x, radius_y, row_offset, fill_alpha
// m_*       out  tdata: half_width, outer_fade_alpha, inner_fade_alpha;
//                tuser: span_valid
//
// One transaction enters per cycle while the output is not stalled; the pipeline
// is made of the three front stages (squares, difference, product), the divider
// with one quotient bit per stage and the square root with one root bit per stage.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stage holds while the stage after it is full and not moving, so empty
// stages are filled even while the output transaction waits.
`include "ellipse_span_with_soft_edge_assert.svh"

module ellipse_span_with_soft_edge #(
	parameter int RADIUS_BITS = 11,
	parameter int ROOT_BITS = 16,
	localparam int IN_BITS = 3 * RADIUS_BITS + 1 + ellspan_pkg::ALPHA_BITS,
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// radius_x, radius_y, row_offset, fill_alpha, zero padding
	input  logic [IN_W-1:0]                    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// half_width, outer_fade_alpha, inner_fade_alpha, zero padding
	output logic [ellspan_pkg::OUT_DATA_W-1:0] m_tdata,
	// span_valid
	output logic                               m_tuser
);
	import ellspan_pkg::*;

	localparam int R = RADIUS_BITS;
	localparam int QW = 2 * RADIUS_BITS;

	logic [R-1:0]          radius_x;
	logic [R-1:0]          radius_y;
	logic [R:0]            row_offset;
	logic [ALPHA_BITS-1:0] fill_alpha;
	logic [R:0]            mag;
	side_t                 side_in;

	logic          vld_s1;
	logic [QW-1:0] rx2_s1;
	logic [QW-1:0] ry2_s1;
	logic [QW-1:0] mag2_s1;
	side_t         side_s1;

	logic          vld_s2;
	logic [QW-1:0] rx2_s2;
	logic [QW-1:0] ry2_s2;
	logic [QW-1:0] d_s2;
	side_t         side_s2;

	logic            vld_s3;
	logic [2*QW-1:0] num_s3;
	logic [QW-1:0]   den_s3;
	side_t           side_s3;

	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	logic          div_in_ready;
	logic          div_valid;
	logic [QW-1:0] div_quo;
	side_t         div_side;
	logic          sq_in_ready;
	logic [ROOT_BITS-1:0] sq_root;
	side_t         sq_side;

	logic                       span_valid;
	logic [HALF_WIDTH_BITS-1:0] half_width;
	logic [ALPHA_BITS-1:0]      outer_fade_alpha;
	logic [ALPHA_BITS-1:0]      inner_fade_alpha;

	assign radius_x   = s_tdata[R-1:0];
	assign radius_y   = s_tdata[2*R-1:R];
	assign row_offset = s_tdata[3*R:2*R];
	assign fill_alpha = s_tdata[3*R+ALPHA_BITS:3*R+1];

	// The most negative offset maps to a magnitude of 2^R, which is never in range.
	assign mag = row_offset[R] ? (~row_offset) + (R+1)'(1) : row_offset;

	always_comb begin
		side_in.ok = (radius_x != '0) && (radius_y != '0) && (fill_alpha != '0)
			&& (mag <= {1'b0, radius_y});
		side_in.outer = div3({1'b0, fill_alpha});
		side_in.inner = div3({fill_alpha, 1'b0});
	end

	assign rdy_s3   = !vld_s3 || div_in_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			rx2_s1  <= QW'(radius_x) * QW'(radius_x);
			ry2_s1  <= QW'(radius_y) * QW'(radius_y);
			mag2_s1 <= QW'(mag[R-1:0]) * QW'(mag[R-1:0]);
			side_s1 <= side_in;
		end
		if (rdy_s2 && vld_s1) begin
			rx2_s2  <= rx2_s1;
			ry2_s2  <= ry2_s1;
			d_s2    <= ry2_s1 - mag2_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3 && vld_s2) begin
			num_s3  <= (2*QW)'(rx2_s2) * (2*QW)'(d_s2);
			den_s3  <= ry2_s2;
			side_s3 <= side_s2;
		end
	end

	ellspan_div #(
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_ready (div_in_ready),
		.num      (num_s3),
		.den      (den_s3),
		.in_side  (side_s3),
		.out_valid(div_valid),
		.out_ready(sq_in_ready),
		.quo      (div_quo),
		.out_side (div_side)
	);

	ellspan_sqrt #(
		.QW(QW),
		.RB(ROOT_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (sq_in_ready),
		.rad      (div_quo),
		.in_side  (div_side),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.root     (sq_root),
		.out_side (sq_side)
	);

	assign span_valid       = sq_side.ok;
	assign half_width       = span_valid ? HALF_WIDTH_BITS'(sq_root) : '0;
	assign outer_fade_alpha = span_valid ? sq_side.outer : '0;
	assign inner_fade_alpha = span_valid ? sq_side.inner : '0;

	assign m_tuser = span_valid;
	assign m_tdata = OUT_DATA_W'({inner_fade_alpha, outer_fade_alpha, half_width});

	`ELLSPAN_CHECK(a_stall_from_sink, !s_tready, m_tvalid && !m_tready)
	`ELLSPAN_CHECK_NEXT(a_accept_fills_s1, s_tvalid && s_tready, vld_s1)
	`ELLSPAN_CHECK(a_dead_span_zero, m_tvalid && !m_tuser,
		(half_width == '0) && (outer_fade_alpha == '0) && (inner_fade_alpha == '0))
	`ELLSPAN_CHECK(a_fade_ratio, m_tvalid && m_tuser,
		((ALPHA_BITS+1)'(inner_fade_alpha) == {outer_fade_alpha, 1'b0})
		|| ((ALPHA_BITS+1)'(inner_fade_alpha) == {outer_fade_alpha, 1'b1}))

endmodule

### rtl/ellspan_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ellspan_pkg for the sideband type.
module ellspan_div #(
	parameter int QW = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2*QW-1:0]     num,
	input  logic [QW-1:0]       den,
	input  ellspan_pkg::side_t  in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [QW-1:0]       quo,
	output ellspan_pkg::side_t  out_side
);
	import ellspan_pkg::*;

	logic [QW-1:0] vld_s;
	logic [QW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [QW-1:0] den_s  [QW];
	side_t         side_s [QW];

	logic [QW:0]   rdy;
	logic [QW-1:0] pv;
	logic [QW-1:0] prem  [QW];
	logic [QW-1:0] plow  [QW];
	logic [QW-1:0] pquo  [QW];
	logic [QW-1:0] pden  [QW];
	side_t         pside [QW];
	logic [QW-1:0] nrem  [QW];
	logic [QW-1:0] ge;

	// The quotient is known to fit in QW bits, so the upper half of the
	// dividend is already below the divisor and seeds the remainder.
	always_comb begin
		logic [QW:0] sh;
		logic [QW:0] diff;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				pv[k]    = in_valid;
				prem[k]  = num[2*QW-1:QW];
				plow[k]  = num[QW-1:0];
				pquo[k]  = '0;
				pden[k]  = den;
				pside[k] = in_side;
			end else begin
				pv[k]    = vld_s[k-1];
				prem[k]  = rem_s[k-1];
				plow[k]  = low_s[k-1];
				pquo[k]  = quo_s[k-1];
				pden[k]  = den_s[k-1];
				pside[k] = side_s[k-1];
			end
			sh = {prem[k], plow[k][QW-1]};
			diff = sh - {1'b0, pden[k]};
			ge[k] = sh >= {1'b0, pden[k]};
			nrem[k] = ge[k] ? diff[QW-1:0] : sh[QW-1:0];
		end
	end

	always_comb begin
		rdy[QW] = out_ready;
		for (int k = QW - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < QW; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= pv[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			if (rdy[k] && pv[k]) begin
				rem_s[k]  <= nrem[k];
				low_s[k]  <= plow[k] << 1;
				quo_s[k]  <= {pquo[k][QW-2:0], ge[k]};
				den_s[k]  <= pden[k];
				side_s[k] <= pside[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

### rtl/ellspan_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on ellspan_pkg for the sideband type.
module ellspan_sqrt #(
	parameter int QW = 22,
	parameter int RB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [QW-1:0]       rad,
	input  ellspan_pkg::side_t  in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RB-1:0]       root,
	output ellspan_pkg::side_t  out_side
);
	import ellspan_pkg::*;

	localparam int XW = (QW > 2 * RB) ? QW : 2 * RB;

	logic [XW-1:0] qx;
	logic          over_in;

	logic [RB-1:0]   vld_s;
	logic [RB-1:0]   over_s;
	logic [2*RB-1:0] rad_s  [RB];
	logic [RB:0]     rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	side_t           side_s [RB];

	logic [RB:0]     rdy;
	logic [RB-1:0]   pv;
	logic [RB-1:0]   pover;
	logic [2*RB-1:0] prad  [RB];
	logic [RB:0]     prem  [RB];
	logic [RB-1:0]   proot [RB];
	side_t           pside [RB];
	logic [RB:0]     nrem  [RB];
	logic [RB-1:0]   ge;

	// A radicand at or above 2^(2*RB) is flagged as over range, and the root
	// then saturates to all ones.
	assign qx = XW'(rad);
	assign over_in = (qx >> (2 * RB)) != '0;

	always_comb begin
		logic [RB+1:0] sh;
		logic [RB+1:0] trial;
		for (int k = 0; k < RB; k++) begin
			if (k == 0) begin
				pv[k]    = in_valid;
				pover[k] = over_in;
				prad[k]  = qx[2*RB-1:0];
				prem[k]  = '0;
				proot[k] = '0;
				pside[k] = in_side;
			end else begin
				pv[k]    = vld_s[k-1];
				pover[k] = over_s[k-1];
				prad[k]  = rad_s[k-1];
				prem[k]  = rem_s[k-1];
				proot[k] = root_s[k-1];
				pside[k] = side_s[k-1];
			end
			sh = {prem[k][RB-1:0], prad[k][2*RB-1:2*RB-2]};
			trial = {proot[k], 2'b01};
			ge[k] = sh >= trial;
			nrem[k] = ge[k] ? (RB+1)'(sh - trial) : (RB+1)'(sh);
		end
	end

	always_comb begin
		rdy[RB] = out_ready;
		for (int k = RB - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < RB; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= pv[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RB; k++) begin
			if (rdy[k] && pv[k]) begin
				over_s[k] <= pover[k];
				rad_s[k]  <= prad[k] << 2;
				rem_s[k]  <= nrem[k];
				root_s[k] <= {proot[k][RB-2:0], ge[k]};
				side_s[k] <= pside[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[RB-1];
	assign root      = over_s[RB-1] ? '1 : root_s[RB-1];
	assign out_side  = side_s[RB-1];

endmodule
